>>> rtl/core/jps_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Sizes, register indexes, reset values and the structs passed between the
// line buffer window and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package jps_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int MIN_DIM  = 3;

  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 8;
  localparam int ADDR_W   = COL_W + 1;
  localparam int POS_W    = 7;

  localparam int VAL_W    = 32;
  localparam int WEIGHT_W = 24;
  localparam int SUM_W    = VAL_W + 1;
  localparam int PROD_W   = SUM_W + WEIGHT_W + 1;
  localparam int PSRC_W   = VAL_W + WEIGHT_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int FRAC_SH  = WEIGHT_W;
  localparam int Q_W      = ACC_W - FRAC_SH;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SOURCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_X_RST      = 24'd4194304;
  localparam logic [WEIGHT_W-1:0] WEIGHT_Y_RST      = 24'd4194304;
  localparam logic [WEIGHT_W-1:0] WEIGHT_SOURCE_RST = 24'd67580;
  localparam logic [DIM_W-1:0]    GRID_COLS_RST     = 8'd100;
  localparam logic [DIM_W-1:0]    GRID_ROWS_RST     = 8'd100;

  typedef struct packed {
    logic [WEIGHT_W-1:0] wx;
    logic [WEIGHT_W-1:0] wy;
    logic [WEIGHT_W-1:0] wsrc;
  } weights_t;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } dims_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } pos_t;

  typedef struct packed {
    logic [VAL_W-1:0] east;
    logic [VAL_W-1:0] west;
    logic [VAL_W-1:0] north;
    logic [VAL_W-1:0] south;
    logic [VAL_W-1:0] src;
    pos_t             pos;
  } stencil_t;

endpackage

`default_nettype wire

>>> rtl/core/jps_window.sv
// ----------------------------------------------------------------------------
// Stencil window
// Raster counters, the two-row line buffer of old values, the one-row line
// buffer of sources and the tap registers that assemble one stencil per item.
// ----------------------------------------------------------------------------
`default_nettype none

module jps_window (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire jps_pkg::dims_t              dims,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [jps_pkg::VAL_W-1:0]   old_value,
  input  wire logic [jps_pkg::VAL_W-1:0]   source_value,
  output logic                             st_valid,
  input  wire logic                        st_ready,
  output jps_pkg::stencil_t                st
);

  logic [jps_pkg::VAL_W-1:0] old_mem [2*jps_pkg::MAX_COLS];
  logic [jps_pkg::VAL_W-1:0] src_mem [jps_pkg::MAX_COLS];

  logic [jps_pkg::COL_W-1:0]  col_count;
  logic [jps_pkg::ROW_W-1:0]  row_count;
  logic [jps_pkg::VAL_W-1:0]  left_value;

  logic [jps_pkg::COL_W-1:0]  cur_c;
  logic [jps_pkg::ROW_W-1:0]  cur_r;
  logic [jps_pkg::DIM_W-1:0]  c_inc;
  logic [jps_pkg::DIM_W-1:0]  r_inc;
  logic [jps_pkg::DIM_W-1:0]  cols_m1;
  logic [jps_pkg::DIM_W-1:0]  rows_m1;
  logic [jps_pkg::ADDR_W-1:0] wr_addr;
  logic [jps_pkg::ADDR_W-1:0] north_addr;
  logic [jps_pkg::ADDR_W-1:0] east_addr;
  logic                       accept;
  logic                       emit;
  jps_pkg::pos_t              pos_next;

  logic [jps_pkg::VAL_W-1:0]  north_rd;
  logic [jps_pkg::VAL_W-1:0]  east_rd;
  logic [jps_pkg::VAL_W-1:0]  src_rd;
  logic [jps_pkg::VAL_W-1:0]  east_d1;
  logic [jps_pkg::VAL_W-1:0]  east_d2;

  logic                       s1_valid;
  logic                       s1_emit;
  logic [jps_pkg::VAL_W-1:0]  s1_south;
  logic [jps_pkg::VAL_W-1:0]  s1_src;
  jps_pkg::pos_t              s1_pos;

  assign in_ready = !s1_valid || !s1_emit || st_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_c = ({1'b0, col_count} >= dims.cols) ? '0 : col_count;
    cur_r = ({1'b0, row_count} >= dims.rows) ? '0 : row_count;
    c_inc = {1'b0, cur_c} + jps_pkg::DIM_W'(1);
    r_inc = {1'b0, cur_r} + jps_pkg::DIM_W'(1);
    cols_m1 = dims.cols - jps_pkg::DIM_W'(1);
    rows_m1 = dims.rows - jps_pkg::DIM_W'(1);
    north_addr = {cur_r[0], cur_c - jps_pkg::COL_W'(1)};
    east_addr  = {~cur_r[0], cur_c};
    if (cur_c == '0) begin
      wr_addr = {~cur_r[0], cols_m1[jps_pkg::COL_W-1:0]};
    end else begin
      wr_addr = north_addr;
    end
    emit = (cur_c >= jps_pkg::COL_W'(2)) && (cur_r >= jps_pkg::ROW_W'(2));
    pos_next.row  = jps_pkg::POS_W'(cur_r - jps_pkg::ROW_W'(1));
    pos_next.col  = jps_pkg::POS_W'(cur_c - jps_pkg::COL_W'(1));
    pos_next.last = ({1'b0, cur_r} == rows_m1) && ({1'b0, cur_c} == cols_m1);
  end

  // Line buffers: read before write, so a same-address read sees the old entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_mem[wr_addr] <= left_value;
      north_rd         <= old_mem[north_addr];
      east_rd          <= old_mem[east_addr];
      src_mem[cur_c]   <= source_value;
      src_rd           <= src_mem[cur_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_value <= '0;
    end else if (accept) begin
      left_value <= old_value;
      if (c_inc >= dims.cols) begin
        col_count <= '0;
        row_count <= (r_inc >= dims.rows) ? '0 : r_inc[jps_pkg::ROW_W-1:0];
      end else begin
        col_count <= c_inc[jps_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  // The source read by the previous item belongs to the row above, one column left.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit  <= emit;
      s1_south <= left_value;
      s1_src   <= src_rd;
      s1_pos   <= pos_next;
    end
    if (s1_valid && in_ready) begin
      east_d1 <= east_rd;
      east_d2 <= east_d1;
    end
  end

  assign st_valid = s1_valid && s1_emit;

  always_comb begin
    st.east  = east_rd;
    st.west  = east_d2;
    st.north = north_rd;
    st.south = s1_south;
    st.src   = s1_src;
    st.pos   = s1_pos;
  end

endmodule

`default_nettype wire

>>> rtl/core/jps_datapath.sv
// ----------------------------------------------------------------------------
// Stencil arithmetic pipeline
// Neighbor sums, weight products, rounded accumulation and saturation, with
// per-stage valid bits so bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module jps_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire jps_pkg::weights_t          weights,
  input  wire logic                       st_valid,
  output logic                            st_ready,
  input  wire jps_pkg::stencil_t          st,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [jps_pkg::VAL_W-1:0]       new_value,
  output jps_pkg::pos_t                   out_pos
);

  localparam logic signed [jps_pkg::ACC_W-1:0] ROUND_HALF =
    jps_pkg::ACC_W'(1) <<< (jps_pkg::FRAC_SH - 1);

  logic free_o, free4, free3;

  logic                               s2_valid;
  logic signed [jps_pkg::SUM_W-1:0]   s2_ew;
  logic signed [jps_pkg::SUM_W-1:0]   s2_ns;
  logic signed [jps_pkg::VAL_W-1:0]   s2_src;
  jps_pkg::pos_t                      s2_pos;

  logic                               s3_valid;
  logic signed [jps_pkg::PROD_W-1:0]  s3_pew;
  logic signed [jps_pkg::PROD_W-1:0]  s3_pns;
  logic signed [jps_pkg::PSRC_W-1:0]  s3_psrc;
  jps_pkg::pos_t                      s3_pos;

  logic                               s4_valid;
  logic signed [jps_pkg::ACC_W-1:0]   s4_acc;
  jps_pkg::pos_t                      s4_pos;

  logic signed [jps_pkg::ACC_W-1:0]   acc_next;
  logic signed [jps_pkg::Q_W-1:0]     q;
  logic [jps_pkg::VAL_W-1:0]          sat_value;

  assign free_o   = !out_valid || out_ready;
  assign free4    = !s4_valid || free_o;
  assign free3    = !s3_valid || free4;
  assign st_ready = !s2_valid || free3;

  always_comb begin
    acc_next = {{2{s3_pew[jps_pkg::PROD_W-1]}}, s3_pew}
             + {{2{s3_pns[jps_pkg::PROD_W-1]}}, s3_pns}
             - {{(jps_pkg::ACC_W - jps_pkg::PSRC_W){s3_psrc[jps_pkg::PSRC_W-1]}}, s3_psrc}
             + ROUND_HALF;
    q = s4_acc[jps_pkg::ACC_W-1:jps_pkg::FRAC_SH];
    if (!q[jps_pkg::Q_W-1] && (|q[jps_pkg::Q_W-2:jps_pkg::VAL_W-1])) begin
      sat_value = {1'b0, {(jps_pkg::VAL_W-1){1'b1}}};
    end else if (q[jps_pkg::Q_W-1] && !(&q[jps_pkg::Q_W-2:jps_pkg::VAL_W-1])) begin
      sat_value = {1'b1, {(jps_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat_value = q[jps_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (st_ready) s2_valid <= st_valid;
      if (free3)    s3_valid <= s2_valid;
      if (free4)    s4_valid <= s3_valid;
      if (free_o)   out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      s2_ew  <= $signed({st.east[jps_pkg::VAL_W-1], st.east})
              + $signed({st.west[jps_pkg::VAL_W-1], st.west});
      s2_ns  <= $signed({st.north[jps_pkg::VAL_W-1], st.north})
              + $signed({st.south[jps_pkg::VAL_W-1], st.south});
      s2_src <= $signed(st.src);
      s2_pos <= st.pos;
    end
    if (free3 && s2_valid) begin
      s3_pew  <= s2_ew * $signed({1'b0, weights.wx});
      s3_pns  <= s2_ns * $signed({1'b0, weights.wy});
      s3_psrc <= s2_src * $signed({1'b0, weights.wsrc});
      s3_pos  <= s2_pos;
    end
    if (free4 && s3_valid) begin
      s4_acc <= acc_next;
      s4_pos <= s3_pos;
    end
    if (free_o && s4_valid) begin
      new_value <= sat_value;
      out_pos   <= s4_pos;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/jacobi_poisson_stencil_sweep_core.sv
// ----------------------------------------------------------------------------
// Jacobi five-point Poisson stencil sweep
// One Jacobi sweep over a streamed grid; emits the new value of each interior
// cell from line buffers of the previous rows.
// ----------------------------------------------------------------------------
// Usage: software streams the whole grid once per iteration on s_axis, one
// cell per item in raster order (row by row, column 0 first), with the old
// potential and the source term of that cell. Weights and grid size are set on
// the cfg write port while the block is idle; grid size is clamped to 3..128.
// m_axis carries one item for each interior cell, in raster order, with its
// row and column; tlast marks the final interior cell of the sweep. Boundary
// cells produce no item.
// Throughput is one cell per clock cycle unless m_axis stalls: the line
// buffers are read at two addresses and written at one in the same cycle as
// the cell is taken. The result for cell (r, c) is computed when cell
// (r+1, c+1) arrives and moves through s1 to s4 into the output register.
// A stalled receiver holds the output register; the five-stage pipeline
// keeps taking cells until its bubbles are filled, then drops s_axis_tready.
// Reset clears the raster position, the pipeline and the registers to their
// defaults; line buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_poisson_stencil_sweep_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [jps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jps_pkg::WEIGHT_W-1:0]    cfg_wr_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [63:0]                     s_axis_tdata,  // old_value, source_value
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [47:0]                          m_axis_tdata,  // new_value, row, col, zeros
  output logic                                 m_axis_tlast
);

  jps_pkg::weights_t          weights;
  logic [jps_pkg::DIM_W-1:0]  grid_cols;
  logic [jps_pkg::DIM_W-1:0]  grid_rows;
  jps_pkg::dims_t             dims;

  logic                       st_valid;
  logic                       st_ready;
  jps_pkg::stencil_t          st;
  logic [jps_pkg::VAL_W-1:0]  new_value;
  jps_pkg::pos_t              out_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights.wx   <= jps_pkg::WEIGHT_X_RST;
      weights.wy   <= jps_pkg::WEIGHT_Y_RST;
      weights.wsrc <= jps_pkg::WEIGHT_SOURCE_RST;
      grid_cols    <= jps_pkg::GRID_COLS_RST;
      grid_rows    <= jps_pkg::GRID_ROWS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        jps_pkg::REG_WEIGHT_X:      weights.wx   <= cfg_wr_data;
        jps_pkg::REG_WEIGHT_Y:      weights.wy   <= cfg_wr_data;
        jps_pkg::REG_WEIGHT_SOURCE: weights.wsrc <= cfg_wr_data;
        jps_pkg::REG_GRID_COLS:     grid_cols    <= cfg_wr_data[jps_pkg::DIM_W-1:0];
        jps_pkg::REG_GRID_ROWS:     grid_rows    <= cfg_wr_data[jps_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_cols < jps_pkg::DIM_W'(jps_pkg::MIN_DIM)) begin
      dims.cols = jps_pkg::DIM_W'(jps_pkg::MIN_DIM);
    end else if (grid_cols > jps_pkg::DIM_W'(jps_pkg::MAX_COLS)) begin
      dims.cols = jps_pkg::DIM_W'(jps_pkg::MAX_COLS);
    end else begin
      dims.cols = grid_cols;
    end
    if (grid_rows < jps_pkg::DIM_W'(jps_pkg::MIN_DIM)) begin
      dims.rows = jps_pkg::DIM_W'(jps_pkg::MIN_DIM);
    end else if (grid_rows > jps_pkg::DIM_W'(jps_pkg::MAX_ROWS)) begin
      dims.rows = jps_pkg::DIM_W'(jps_pkg::MAX_ROWS);
    end else begin
      dims.rows = grid_rows;
    end
  end

  jps_window u_window (
    .clk          (clk),
    .rst          (rst),
    .dims         (dims),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .old_value    (s_axis_tdata[31:0]),
    .source_value (s_axis_tdata[63:32]),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st           (st)
  );

  jps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .weights   (weights),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .new_value (new_value),
    .out_pos   (out_pos)
  );

  assign m_axis_tdata = {2'b00, out_pos.col, out_pos.row, new_value};
  assign m_axis_tlast = out_pos.last;

endmodule

`default_nettype wire

>>> rtl/core/jps_checker.sv
// ----------------------------------------------------------------------------
// Stencil sweep port checker
// Watches the top-level ports over time and reports behavior the block
// must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module jps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Emitted cells never lie in row 0 or column 0.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[38:32] != 7'd0) && (m_axis_tdata[45:39] != 7'd0))
    else $error("boundary cell emitted");

  // The output is not valid when reset has just been released.
  a_no_early_out: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("output valid before any input item");

endmodule

bind jacobi_poisson_stencil_sweep_core jps_checker u_jps_checker (.*);

`default_nettype wire
